[design/drq_pkg.sv]
package drq_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int ID_W        = 6;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCHEDULE   = 2'd0,
        MODE_DESCHEDULE = 2'd1,
        MODE_DISPATCH   = 2'd2,
        MODE_COMPLETE   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE       = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_CANCELLED  = 2'd2,
        ST_NO_HANDLER = 2'd3
    } t_status;

    // per-entry flags
    typedef struct packed {
        logic queued;
        logic scheduled;
        logic handler;
    } t_entry_bits;

endpackage

[design/drq_entry_table.sv]
module drq_entry_table #(
    parameter int DEPTH = drq_pkg::ENTRIES_DEF,
    parameter int AW    = drq_pkg::ID_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [AW-1:0]        i_rd_addr,
    output drq_pkg::t_entry_bits o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  drq_pkg::t_entry_bits i_wr_data
);

    drq_pkg::t_entry_bits r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    drq_pkg::t_entry_bits r_rd_data;
    logic                 r_rd_valid;

    // storage, read data registered
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // valid bits: an entry never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[design/deduplicating_ready_queue_unit.sv]
// An accepted item passes FETCH and EXEC, and the result strobe is
// registered at the end of EXEC. No new item is taken while busy. A dispatch
// reads the head slot, then the table at the popped ID: two dependent reads.
// Reset: synchronous, active low; pointers, count and entry valid bits clear
// at once, so no clearing pass. The receiver cannot stall results.
module deduplicating_ready_queue_unit #(
    parameter int ENTRIES = drq_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [drq_pkg::MODE_W-1:0]    i_mode,
    input  logic [drq_pkg::ID_W-1:0]      i_entry_id,
    input  logic                          i_has_handler,
    input  logic                          i_not_done,
    output logic                          o_strobe,
    output logic [drq_pkg::STATUS_W-1:0]  o_dispatch_status,
    output logic [drq_pkg::ID_W-1:0]      o_dispatched_id,
    output logic                          o_queue_empty
);

    // FIFO slots and count
    localparam int FA = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    // IDs are ID_W bits wide, so the entry table never needs more rows
    localparam int BD = (ENTRIES < (1 << drq_pkg::ID_W)) ? ENTRIES : (1 << drq_pkg::ID_W);
    localparam int BA = $clog2(BD);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                       r_state;
    drq_pkg::t_mode               r_mode;
    logic [drq_pkg::ID_W-1:0]     r_id;
    logic                         r_hh;
    logic                         r_nd;
    logic [FA-1:0]                r_head;
    logic [FA-1:0]                r_tail;
    logic [CW-1:0]                r_count;
    logic [drq_pkg::ID_W-1:0]     r_fifo [ENTRIES];
    logic [drq_pkg::ID_W-1:0]     r_fifo_rd;
    logic                         r_strobe;
    drq_pkg::t_status             r_status;
    logic [drq_pkg::ID_W-1:0]     r_pop_id;
    logic                         r_empty;

    logic                         accept;
    logic [BA-1:0]                tbl_rd_addr;
    drq_pkg::t_entry_bits         tbl_rd;
    logic                         tbl_wr_en;
    logic [BA-1:0]                tbl_wr_addr;
    drq_pkg::t_entry_bits         tbl_wr;
    logic                         push;
    logic                         pop;
    logic                         id_ok;
    logic                         pop_ok;
    logic                         full;
    drq_pkg::t_status             n_status;
    logic [drq_pkg::ID_W-1:0]     n_pop_id;
    logic [CW-1:0]                n_count;
    logic [FA-1:0]                n_head;
    logic [FA-1:0]                n_tail;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // ---------------------------------------------------------------
    // sequencer: IDLE (accept, read head slot) -> FETCH (read entry
    // table at the item's ID or at the popped ID) -> EXEC (update)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_FETCH;
                end
                S_FETCH: r_state <= S_EXEC;
                S_EXEC:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= drq_pkg::t_mode'(i_mode);
            r_id   <= i_entry_id;
            r_hh   <= i_has_handler;
            r_nd   <= i_not_done;
        end
    end

    // ID FIFO storage: read head while idle, write tail on a push
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_fifo_rd <= r_fifo[r_head];
        end
        if (push) begin
            r_fifo[r_tail] <= r_id;
        end
    end

    // entry table read address
    always_comb begin
        tbl_rd_addr = i_entry_id[BA-1:0];
        if (r_state == S_FETCH) begin
            if (r_mode == drq_pkg::MODE_DISPATCH && r_count != '0) begin
                tbl_rd_addr = r_fifo_rd[BA-1:0];
            end else begin
                tbl_rd_addr = r_id[BA-1:0];
            end
        end
    end

    drq_entry_table #(
        .DEPTH (BD),
        .AW    (BA)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr)
    );

    assign id_ok  = (32'(r_id) < ENTRIES);
    assign pop_ok = (32'(r_fifo_rd) < ENTRIES);
    assign full   = (32'(r_count) >= ENTRIES);

    // ---------------------------------------------------------------
    // update in EXEC: table data is for the addressed entry
    // ---------------------------------------------------------------
    always_comb begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_id[BA-1:0];
        tbl_wr      = tbl_rd;
        push        = 1'b0;
        pop         = 1'b0;
        n_status    = drq_pkg::ST_NONE;
        n_pop_id    = '0;
        if (r_state == S_EXEC) begin
            case (r_mode)
                drq_pkg::MODE_SCHEDULE: begin
                    if (id_ok) begin
                        tbl_wr_en         = 1'b1;
                        tbl_wr.scheduled  = 1'b1;
                        tbl_wr.handler    = r_hh;
                        if (!tbl_rd.queued && !full) begin
                            push          = 1'b1;
                            tbl_wr.queued = 1'b1;
                        end
                    end
                end
                drq_pkg::MODE_DESCHEDULE: begin
                    if (id_ok) begin
                        tbl_wr_en        = 1'b1;
                        tbl_wr.scheduled = 1'b0;
                    end
                end
                drq_pkg::MODE_DISPATCH: begin
                    if (r_count != '0) begin
                        pop      = 1'b1;
                        n_pop_id = r_fifo_rd;
                        n_status = drq_pkg::ST_CANCELLED;
                        if (pop_ok) begin
                            tbl_wr_en     = 1'b1;
                            tbl_wr_addr   = r_fifo_rd[BA-1:0];
                            tbl_wr.queued = 1'b0;
                            if (tbl_rd.scheduled) begin
                                tbl_wr.scheduled = 1'b0;
                                n_status = tbl_rd.handler ? drq_pkg::ST_DISPATCHED
                                                          : drq_pkg::ST_NO_HANDLER;
                            end
                        end
                    end
                end
                drq_pkg::MODE_COMPLETE: begin
                    if (id_ok && r_nd) begin
                        tbl_wr_en        = 1'b1;
                        tbl_wr.scheduled = 1'b1;
                        if (!tbl_rd.queued && !full) begin
                            push          = 1'b1;
                            tbl_wr.queued = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // pointer and count next values, wrap at ENTRIES
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (pop) begin
            n_head  = (r_head == FA'(ENTRIES - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (push) begin
            n_tail  = (r_tail == FA'(ENTRIES - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_strobe <= (r_state == S_EXEC);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_pop_id <= n_pop_id;
            r_empty  <= (n_count == '0);
        end
    end

    assign o_strobe          = r_strobe;
    assign o_dispatch_status = r_status;
    assign o_dispatched_id   = r_pop_id;
    assign o_queue_empty     = r_empty;

`ifndef NO_ASSERTIONS
    // a result only follows an update step
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EXEC))
        else $error("result strobe without update step");

    // count never exceeds the FIFO depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ENTRIES)
        else $error("FIFO count above depth");

    // reported empty flag matches the count
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_queue_empty == (r_count == '0)))
        else $error("queue_empty disagrees with count");

    // no pop reported means no ID reported
    a_none_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_dispatch_status == drq_pkg::ST_NONE) |-> (o_dispatched_id == '0))
        else $error("ID reported without a pop");

    // pointers stay consistent with the count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty FIFO with head and tail apart");
`endif

endmodule
